### sv/permutation_unrank_core_defines.svh
// ---------------------------------------------------------------------------
// Permutation unrank core: assertion macros
// Shared concurrent check forms for the unrank controller and datapath.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_CORE_DEFINES_SVH
`define PERMUTATION_UNRANK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define PU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank package
// Fixed widths, controller states, command/status bundles and the
// reciprocal table used to split the rank into factorial-base digits.
// ---------------------------------------------------------------------------
package pu_pkg;

  localparam int RANK_W   = 10;
  localparam int CFG_W    = 3;
  localparam int SYM_W    = 3;
  localparam int POS_W    = 3;
  localparam int DIGIT_W  = 3;
  localparam int RADIX_W  = 4;
  localparam int CNT_W    = 4;
  localparam int RECIP_W  = 16;
  localparam int RECIP_SH = 16;

  localparam logic [CFG_W-1:0]   PERM_SIZE_RST = 3'd6;
  localparam logic [RADIX_W-1:0] RADIX_FIRST   = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic mod;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic size_one;
    logic digit_last;
    logic emit_last;
  } status_t;

  // Scaled reciprocal ceil(2^16 / radix); exact quotient for 10-bit dividends
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] radix);
    logic [RECIP_W-1:0] m;
    begin
      unique case (radix)
        4'd2:    m = 16'd32768;
        4'd3:    m = 16'd21846;
        4'd4:    m = 16'd16384;
        4'd5:    m = 16'd13108;
        4'd6:    m = 16'd10923;
        4'd7:    m = 16'd9363;
        4'd8:    m = 16'd8192;
        default: m = 16'd0;
      endcase
      return m;
    end
  endfunction

endpackage

### sv/pu_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank datapath
// Size register, digit extraction by reciprocal multiply, digit store,
// unused-symbol selection and the registered result word.
// ---------------------------------------------------------------------------
`include "permutation_unrank_core_defines.svh"

module pu_dpath #(
  parameter int MAX_SIZE = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [pu_pkg::CFG_W-1:0]    cfg_data,
  input  logic [pu_pkg::RANK_W-1:0]   in_rank,
  input  pu_pkg::cmd_t                cmd,
  output pu_pkg::status_t             status,
  output logic                        out_strobe,
  output logic [pu_pkg::SYM_W-1:0]    out_element,
  output logic [pu_pkg::POS_W-1:0]    out_position,
  output logic                        out_last
);

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW     = $clog2(MAX_SIZE + 1);
  localparam int PROD_W = pu_pkg::RANK_W + pu_pkg::RECIP_W;
  localparam int QM_W   = pu_pkg::RANK_W + pu_pkg::RADIX_W;

  logic [pu_pkg::CFG_W-1:0]    perm_size_r;
  logic [NW-1:0]               size_r;
  logic [pu_pkg::RANK_W-1:0]   rest_r;
  logic [pu_pkg::RANK_W-1:0]   quot_r;
  logic [pu_pkg::RADIX_W-1:0]  radix_r;
  logic [IDX_W-1:0]            dk_r;
  logic [IDX_W-1:0]            pos_r;
  logic [pu_pkg::DIGIT_W-1:0]  digit_r [MAX_SIZE];
  logic [MAX_SIZE-1:0]         used_r;
  logic                        out_strobe_r;
  logic [pu_pkg::SYM_W-1:0]    out_element_r;
  logic [pu_pkg::POS_W-1:0]    out_position_r;
  logic                        out_last_r;

  logic [pu_pkg::CNT_W-1:0]    perm_ext;
  logic [NW-1:0]               size_eff;
  logic [PROD_W-1:0]           prod;
  logic [QM_W-1:0]             qm;
  logic [pu_pkg::RANK_W-1:0]   remd;
  logic [IDX_W-1:0]            dk_idx;
  logic [pu_pkg::DIGIT_W-1:0]  dig;
  logic [pu_pkg::DIGIT_W-1:0]  seen;
  logic                        found;
  logic [IDX_W-1:0]            pick;

  // Clamp the size register to 1..MAX_SIZE
  always_comb begin
    perm_ext = {1'b0, perm_size_r};
    if (perm_size_r == '0) begin
      size_eff = NW'(1);
    end else if (perm_ext > pu_pkg::CNT_W'(MAX_SIZE)) begin
      size_eff = NW'(MAX_SIZE);
    end else begin
      size_eff = NW'(perm_ext);
    end
  end

  // Quotient by reciprocal, then remainder from the registered quotient
  always_comb begin
    prod   = PROD_W'(rest_r) * PROD_W'(pu_pkg::recip(radix_r));
    qm     = QM_W'(quot_r) * QM_W'(radix_r);
    remd   = rest_r - pu_pkg::RANK_W'(qm);
    dk_idx = dk_r - IDX_W'(1);
  end

  // Find the digit-th symbol not yet used
  always_comb begin
    dig   = digit_r[pos_r];
    seen  = '0;
    found = 1'b0;
    pick  = '0;
    for (int s = 0; s < MAX_SIZE; s++) begin
      if (!found && !used_r[s]) begin
        if (seen == dig) begin
          pick  = IDX_W'(s);
          found = 1'b1;
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
  end

  always_comb begin
    status.size_one   = (size_eff == NW'(1));
    status.digit_last = (dk_r == IDX_W'(1));
    status.emit_last  = (NW'(pos_r) == size_r - NW'(1));
  end

  // Size register: take a word whenever the write channel offers one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_size_r <= pu_pkg::PERM_SIZE_RST;
    end else if (cfg_valid) begin
      perm_size_r <= cfg_data;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r  <= size_eff;
      rest_r  <= in_rank;
      radix_r <= pu_pkg::RADIX_FIRST;
      dk_r    <= IDX_W'(size_eff - NW'(1));
      pos_r   <= '0;
      used_r  <= '0;
      for (int i = 0; i < MAX_SIZE; i++) begin
        digit_r[i] <= '0;
      end
    end
    if (cmd.div) begin
      quot_r <= prod[pu_pkg::RECIP_SH +: pu_pkg::RANK_W];
    end
    if (cmd.mod) begin
      digit_r[dk_idx] <= remd[pu_pkg::DIGIT_W-1:0];
      rest_r          <= quot_r;
      radix_r         <= radix_r + 1'b1;
      dk_r            <= dk_idx;
    end
    if (cmd.emit) begin
      used_r[pick] <= 1'b1;
      pos_r        <= pos_r + 1'b1;
    end
  end

  // Result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_element_r  <= pu_pkg::SYM_W'(pick);
      out_position_r <= pu_pkg::POS_W'(pos_r);
      out_last_r     <= status.emit_last;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_element  = out_element_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;

  // Emitted symbol must lie inside the active size
  `PU_ASSERT_NEXT(a_pick_in_range, clk, rst_n, cmd.emit, NW'(out_element_r) < size_r, "pick outside size")
  // A remainder never reaches its radix
  `PU_ASSERT_NOW(a_rem_below_radix, clk, rst_n, cmd.mod, remd < pu_pkg::RANK_W'(radix_r), "remainder too large")

endmodule

### sv/pu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank controller
// Sequences load, digit division/remainder passes and per-position emits.
// ---------------------------------------------------------------------------
`include "permutation_unrank_core_defines.svh"

module pu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pu_pkg::status_t  status,
  output pu_pkg::cmd_t     cmd,
  output logic             busy
);

  pu_pkg::state_t state_r;
  pu_pkg::state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pu_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = status.size_one ? pu_pkg::ST_EMIT : pu_pkg::ST_DIV;
        end
      end
      pu_pkg::ST_DIV: begin
        state_nxt = pu_pkg::ST_MOD;
      end
      pu_pkg::ST_MOD: begin
        state_nxt = status.digit_last ? pu_pkg::ST_EMIT : pu_pkg::ST_DIV;
      end
      pu_pkg::ST_EMIT: begin
        if (status.emit_last) begin
          state_nxt = pu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pu_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    busy     = (state_r != pu_pkg::ST_IDLE);
    cmd.load = (state_r == pu_pkg::ST_IDLE) && start;
    cmd.div  = (state_r == pu_pkg::ST_DIV);
    cmd.mod  = (state_r == pu_pkg::ST_MOD);
    cmd.emit = (state_r == pu_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one datapath command per cycle
  `PU_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping commands")
  // A taken word always leaves idle
  `PU_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, busy, "load did not start work")
  // Final position returns the controller to idle
  `PU_ASSERT_NEXT(a_last_idle, clk, rst_n, cmd.emit && status.emit_last, !busy, "no idle after last")
  // Last digit pass hands over to emitting
  `PU_ASSERT_NEXT(a_mod_emit, clk, rst_n, cmd.mod && status.digit_last, cmd.emit, "digits not followed by emit")

endmodule

### sv/permutation_unrank_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank core
// Turns a rank into the lexicographic permutation of 0..n-1, one word per
// position.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_rank and pulse start while busy is low; the word is taken
//   at that edge. Ranks of n! or more wrap modulo n!.
//   Config: cfg_data is the permutation size n (0 acts as 1, values above
//   MAX_SIZE clamp to MAX_SIZE); a word is taken whenever cfg_valid is high.
//   Write it only while busy is low and no result is pending.
//   Output: n result words, one per cycle, each on out_element/out_position/
//   out_last for exactly one cycle while out_strobe is high; out_last marks
//   position n-1. The receiver cannot stall.
//   Sequence: the word loads at the accepting edge; then a reciprocal
//   multiply and a remainder pass for each of the n-1 digits, then one
//   emit per position. busy stays high until the last position is
//   emitted, so a new word is taken only after the previous rank has
//   been fully emitted.
//   Reset: the size returns to 6 and any rank in progress is dropped.
// ---------------------------------------------------------------------------

module permutation_unrank_core #(
  parameter int MAX_SIZE = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  output logic                       out_strobe,
  output logic [pu_pkg::SYM_W-1:0]   out_element,
  output logic [pu_pkg::POS_W-1:0]   out_position,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pu_pkg::CFG_W-1:0]   cfg_data
);

  pu_pkg::cmd_t    cmd;
  pu_pkg::status_t status;

  // Size register accepts every offered word
  assign cfg_ready = 1'b1;

  pu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pu_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_rank      (in_rank),
    .cmd          (cmd),
    .status       (status),
    .out_strobe   (out_strobe),
    .out_element  (out_element),
    .out_position (out_position),
    .out_last     (out_last)
  );

endmodule

### tb/permutation_unrank_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Permutation unrank core testbench
// Drives ranks through the start/busy command port under every size setting,
// predicts each permutation word by word and compares every strobed word
// against the oldest predicted one.
// ---------------------------------------------------------------------------

module permutation_unrank_core_test;

  localparam int MAX_SIZE     = 6;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE       = 40;
  localparam int RANDOM_ITEMS = 300;
  localparam int PHASES       = 6;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [pu_pkg::SYM_W-1:0] element;
    logic [pu_pkg::POS_W-1:0] position;
    logic                     last;
  } perm_word_t;

  // Predicts permutation words and holds those not yet seen
  class perm_tracker;
    perm_word_t               pending_words[$];
    logic [pu_pkg::CFG_W-1:0] size_reg;
    int                       failures;

    function new();
      size_reg = pu_pkg::PERM_SIZE_RST;
      failures = 0;
    endfunction

    function void set_size(logic [pu_pkg::CFG_W-1:0] value);
      size_reg = value;
    endfunction

    function int live_size();
      int n;
      n = int'(size_reg);
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Split the rank into factorial-base digits, then pick unused symbols
    function void note_rank(logic [pu_pkg::RANK_W-1:0] rank);
      int         n;
      int         rest;
      int         radix;
      int         digit[MAX_SIZE];
      bit         taken[MAX_SIZE];
      int         seen;
      int         pick;
      perm_word_t w;
      n = live_size();
      rest = int'(rank);
      radix = 2;
      for (int k = 0; k < MAX_SIZE; k++) begin
        digit[k] = 0;
        taken[k] = 0;
      end
      for (int k = n - 1; k > 0; k--) begin
        digit[k-1] = rest % radix;
        rest = rest / radix;
        radix++;
      end
      for (int k = 0; k < n; k++) begin
        seen = 0;
        pick = 0;
        for (int s = 0; s < n; s++) begin
          if (!taken[s]) begin
            if (seen == digit[k]) begin
              pick = s;
              break;
            end
            seen++;
          end
        end
        taken[pick] = 1;
        w.element  = pick[pu_pkg::SYM_W-1:0];
        w.position = k[pu_pkg::POS_W-1:0];
        w.last     = (k + 1 == n);
        pending_words.push_back(w);
      end
    endfunction

    // Compare one strobed word with the oldest prediction
    function void check_word(logic [pu_pkg::SYM_W-1:0] element,
                             logic [pu_pkg::POS_W-1:0] position, logic last);
      perm_word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected word: element %0d position %0d last %0d",
               element, position, last);
        failures++;
        return;
      end
      w = pending_words.pop_front();
      if (element !== w.element) begin
        $error("element: expected %0d, actual %0d", w.element, element);
        failures++;
      end
      if (position !== w.position) begin
        $error("position: expected %0d, actual %0d", w.position, position);
        failures++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, actual %0d", w.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  logic                      busy;
  logic [pu_pkg::RANK_W-1:0] in_rank   = '0;
  logic                      out_strobe;
  logic [pu_pkg::SYM_W-1:0]  out_element;
  logic [pu_pkg::POS_W-1:0]  out_position;
  logic                      out_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [pu_pkg::CFG_W-1:0]  cfg_data  = '0;

  perm_tracker board = new();
  int          cycles = 0;

  permutation_unrank_core #(
    .MAX_SIZE (MAX_SIZE)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_rank      (in_rank),
    .out_strobe   (out_strobe),
    .out_element  (out_element),
    .out_position (out_position),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every strobed word
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_word(out_element, out_position, out_last);
    end
  end

  // Hold start until the block takes the word
  task automatic send_rank(input logic [pu_pkg::RANK_W-1:0] rank);
    start   <= 1'b1;
    in_rank <= rank;
    do @(posedge clk); while (busy);
    board.note_rank(rank);
  endtask

  // Drop start and wait out the given gap
  task automatic hold_off(input int gap);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Send one directed rank and rest briefly now and then
  task automatic send_directed(input logic [pu_pkg::RANK_W-1:0] rank);
    int gap;
    gap = $urandom_range(0, 2);
    send_rank(rank);
    if (gap > 0) hold_off(gap);
  endtask

  // Drain the block, then write the size register
  task automatic write_size(input logic [pu_pkg::CFG_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_size(value);
  endtask

  function automatic int size_factorial(input int n);
    int f;
    f = 1;
    for (int i = 2; i <= n; i++) f *= i;
    return f;
  endfunction

  initial begin
    int                        burst;
    int                        fact;
    int                        per_phase;
    logic [pu_pkg::CFG_W-1:0]  size_pick;
    logic [pu_pkg::RANK_W-1:0] rank;

    // Reset
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size, wrap and top ranks
    send_directed(10'd0);
    send_directed(10'd719);
    send_directed(10'd720);
    send_directed(10'd1023);
    send_directed(10'd1);
    send_directed(10'd6);
    send_directed(10'd24);
    // Size one and size zero give a single word
    write_size(3'd1);
    send_directed(10'd0);
    send_directed(10'd1023);
    write_size(3'd0);
    send_directed(10'd0);
    send_directed(10'd513);
    // Size above maximum clamps
    write_size(3'd7);
    send_directed(10'd719);
    send_directed(10'd720);
    write_size(3'd2);
    send_directed(10'd1);
    send_directed(10'd2);
    write_size(3'd3);
    send_directed(10'd5);
    send_directed(10'd6);
    write_size(3'd4);
    send_directed(10'd23);
    write_size(3'd5);
    send_directed(10'd119);

    // Random phases, bursts of ranks with gaps between them
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) size_pick = 3'd6;
      else if (p == 1) size_pick = 3'd1;
      else size_pick = pu_pkg::CFG_W'($urandom_range(0, 7));
      write_size(size_pick);
      fact = size_factorial(board.live_size());
      burst = $urandom_range(1, 12);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          rank = pu_pkg::RANK_W'($urandom_range(0, fact - 1));
        end else begin
          rank = pu_pkg::RANK_W'($urandom_range(0, 1023));
        end
        send_rank(rank);
        burst--;
        if (burst == 0) begin
          hold_off($urandom_range(1, 15));
          burst = $urandom_range(1, 12);
        end
      end
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
